// ----- rtl/aea_pkg.sv -----
package aea_pkg;

  // event kinds
  localparam logic [1:0] KIND_AXIS = 2'd0;
  localparam logic [1:0] KIND_SYNC = 2'd1;

  // axis codes
  localparam logic [15:0] AXIS_X = 16'd0;
  localparam logic [15:0] AXIS_Y = 16'd1;
  localparam logic [15:0] AXIS_Z = 16'd2;

  // configuration register indexes
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_SCALE  = 1'b1;

  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned CFG_W     = SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd167886;

  // time conversion factors
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [9:0]  NS_PER_USEC = 10'd1000;

  // job queue, depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [15:0]        axis_code;
    logic signed [15:0] sample_value;
    logic [31:0]        time_sec;
    logic [19:0]        time_usec;
  } in_item_t;

  typedef struct packed {
    logic [61:0]        timestamp_ns;
    logic signed [39:0] accel_x_scaled;
    logic signed [39:0] accel_y_scaled;
    logic signed [39:0] accel_z_scaled;
  } out_item_t;

  // work handed from the front to the back
  typedef struct packed {
    logic [31:0]        time_sec;
    logic [19:0]        time_usec;
    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic signed [15:0] avg_z;
  } job_t;

endpackage

// ----- rtl/aea_front.sv -----
module aea_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aea_pkg::in_item_t in_data,
  input  logic              accel_enable,
  input  logic              queue_full,
  output logic              push,
  output aea_pkg::job_t     job
);
  import aea_pkg::*;

  logic signed [15:0] latest_x, latest_y, latest_z;
  logic signed [15:0] avg_x, avg_y, avg_z;
  logic [2:0]         seen_bits;
  logic               changed_flag;
  logic               accept;
  logic               take_axis;
  logic               sync_ok;
  logic signed [15:0] avg_x_next, avg_y_next, avg_z_next;

  // (avg + latest) / 2, truncated toward zero
  function automatic logic signed [15:0] avg_step(input logic signed [15:0] avg,
                                                   input logic signed [15:0] latest);
    logic signed [16:0] sum;
    begin
      sum = {avg[15], avg} + {latest[15], latest};
      sum = sum + {16'd0, sum[16]};
      return sum[16:1];
    end
  endfunction

  // classify the incoming beat
  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready && accel_enable;
  assign take_axis = accept && (in_data.event_kind == KIND_AXIS);
  assign sync_ok   = accept && (in_data.event_kind == KIND_SYNC) && changed_flag &&
                     (seen_bits == 3'b111);

  assign avg_x_next = avg_step(avg_x, latest_x);
  assign avg_y_next = avg_step(avg_y, latest_y);
  assign avg_z_next = avg_step(avg_z, latest_z);

  // job for the back end
  assign push          = sync_ok;
  assign job.time_sec  = in_data.time_sec;
  assign job.time_usec = in_data.time_usec;
  assign job.avg_x     = avg_x_next;
  assign job.avg_y     = avg_y_next;
  assign job.avg_z     = avg_z_next;

  // axis capture and averaging state; samples are already 16-bit so no clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_x     <= '0;
      latest_y     <= '0;
      latest_z     <= '0;
      avg_x        <= '0;
      avg_y        <= '0;
      avg_z        <= '0;
      seen_bits    <= '0;
      changed_flag <= 1'b0;
    end else if (take_axis) begin
      case (in_data.axis_code)
        AXIS_X: begin
          if (latest_x != in_data.sample_value) changed_flag <= 1'b1;
          latest_x     <= in_data.sample_value;
          seen_bits[0] <= 1'b1;
        end
        AXIS_Y: begin
          if (latest_y != in_data.sample_value) changed_flag <= 1'b1;
          latest_y     <= in_data.sample_value;
          seen_bits[1] <= 1'b1;
        end
        AXIS_Z: begin
          if (latest_z != in_data.sample_value) changed_flag <= 1'b1;
          latest_z     <= in_data.sample_value;
          seen_bits[2] <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (sync_ok) begin
      avg_x        <= avg_x_next;
      avg_y        <= avg_y_next;
      avg_z        <= avg_z_next;
      seen_bits    <= '0;
      changed_flag <= 1'b0;
    end
  end

`ifndef SYNTH
  // an emitted sample starts a fresh collection
  assert property (@(posedge clk) disable iff (rst)
    push |=> (seen_bits == 3'b000) && !changed_flag)
    else $error("seen bits or changed flag not cleared after emit");
`endif

endmodule

// ----- rtl/aea_queue.sv -----
module aea_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aea_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output aea_pkg::job_t pop_data,
  output logic          not_empty
);
  import aea_pkg::*;

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full      = (count == QUEUE_DEPTH[QUEUE_PTR_W:0]);
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_DEPTH[QUEUE_PTR_W:0])
    else $error("job queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("job queue popped while empty");
`endif

endmodule

// ----- rtl/aea_back.sv -----
module aea_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  aea_pkg::job_t                 job,
  input  logic [aea_pkg::SCALE_W-1:0]   scale_q24,
  output logic                          out_valid,
  input  logic                          out_ready,
  output aea_pkg::out_item_t            out_data
);
  import aea_pkg::*;

  logic               s1_valid;
  logic               s1_load;
  logic               s2_take;
  logic [61:0]        sec_ns;
  logic [29:0]        usec_ns;
  logic signed [39:0] prod_x, prod_y, prod_z;
  logic signed [40:0] mul_x, mul_y, mul_z;
  logic signed [SCALE_W:0] scale_s;

  // pipeline flow control
  assign s2_take   = s1_valid && (!out_valid || out_ready);
  assign s1_load   = job_valid && (!s1_valid || s2_take);
  assign job_ready = s1_load;

  // scale is unsigned, widened so the product is signed; |result| stays in 40 bits
  assign scale_s = $signed({1'b0, scale_q24});
  assign mul_x   = job.avg_x * scale_s;
  assign mul_y   = job.avg_y * scale_s;
  assign mul_z   = job.avg_z * scale_s;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s1_valid || s2_take) s1_valid  <= job_valid;
      if (!out_valid || out_ready) out_valid <= s1_valid;
    end
  end

  // stage 1: multiplies
  always_ff @(posedge clk) begin
    if (s1_load) begin
      sec_ns  <= {30'd0, job.time_sec} * {32'd0, NS_PER_SEC};
      usec_ns <= {10'd0, job.time_usec} * {20'd0, NS_PER_USEC};
      prod_x  <= mul_x[39:0];
      prod_y  <= mul_y[39:0];
      prod_z  <= mul_z[39:0];
    end
  end

  // stage 2: timestamp sum into the output register
  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_data.timestamp_ns   <= sec_ns + {32'd0, usec_ns};
      out_data.accel_x_scaled <= prod_x;
      out_data.accel_y_scaled <= prod_y;
      out_data.accel_z_scaled <= prod_z;
    end
  end

endmodule

// ----- rtl/accel_event_assembler_unit.sv -----
// Acceleration event assembler. Input beats are axis, sync or other events; axis
// events for x, y and z are captured, and a sync event yields one result beat when
// all three axes were seen since the last result and at least one value changed.
// The result holds the event time in nanoseconds and the running average of each
// axis times the Q0.24 scale. The block takes one event per clock cycle while
// the job queue is not full. A result passes through the job queue written by
// the front end that tracks axis state, then two stages in the back end
// (multipliers, then the timestamp adder and output register). A four-entry job
// queue between front and back lets axis events keep flowing while results are
// stalled at the output; input ready drops only when that queue is full. The user
// must write the configuration (index 0 enable, index 1 scale) only while the
// block is idle; the block itself does not enforce this. It takes effect at once.
module accel_event_assembler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  aea_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output aea_pkg::out_item_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [aea_pkg::CFG_W-1:0]   cfg_wdata
);
  import aea_pkg::*;

  logic               accel_enable;
  logic [SCALE_W-1:0] scale_q24;
  logic               push;
  logic               queue_full;
  logic               pop;
  logic               job_valid;
  job_t               push_job;
  job_t               pop_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_enable <= 1'b1;
      scale_q24    <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE: accel_enable <= cfg_wdata[0];
        REG_SCALE:  scale_q24    <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aea_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .accel_enable (accel_enable),
    .queue_full   (queue_full),
    .push         (push),
    .job          (push_job)
  );

  aea_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_job),
    .not_empty (job_valid)
  );

  aea_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (pop),
    .job       (pop_job),
    .scale_q24 (scale_q24),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
